FILE: sv/lpb_pkg.sv
// Shared types and constants for the LED PWM breathing controller.
package lpb_pkg;

    // Field widths
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned STEP_W   = 15;
    localparam int unsigned DUTY_W   = 16;
    localparam int unsigned MODE_W   = 2;

    // Stream payload widths (padded to whole bytes)
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 24;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_STEP = 1'b1;

    // Reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd400;
    localparam logic [STEP_W-1:0]   STEP_RESET    = 15'd10;
    localparam logic [DUTY_W-1:0]   ON_TIME_RESET = 16'd400;

    // LED modes
    typedef enum logic [MODE_W-1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_PULSE = 2'd3
    } t_mode;

    // Result of one timer event
    typedef struct packed {
        logic              led_level;
        logic              reload_written;
        logic [DUTY_W-1:0] reload_value;
    } t_result;

endpackage

FILE: sv/led_pwm_mode_breathing_top.sv
// LED PWM breathing controller: mode decode, pulse ramp and PWM phase toggle.
//
// Each input item is one expiry of the PWM interval timer and yields exactly one result
// item: the LED level for the next interval, a reload flag and the reload count. An item
// is taken into an input register, worked on by one short combinational pass (the pulse
// ramp, duty saturation against the period and the off/on phase choice) and placed in the
// result register, which also updates the ramp and phase state. The result becomes valid
// when the item passes from the input register into the result register.
// One item is accepted every cycle while the result side keeps up. The result register
// parts the two sides, so a stalled output holds one finished item while the next waits
// in the input register. pwm_period and pulse_step are written through the plain write
// port and take effect for the next item processed.
module led_pwm_mode_breathing_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [lpb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lpb_pkg::PERIOD_W-1:0]  i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lpb_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [15:0] duty, [16] blink_phase
    input  logic [lpb_pkg::MODE_W-1:0]    s_axis_tuser,  // [1:0] mode
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lpb_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [0] led_level, [16:1] reload_value
    output logic [0:0]                    m_axis_tuser   // [0] reload_written
);

    // Configuration registers
    logic [lpb_pkg::PERIOD_W-1:0] r_period;
    logic [lpb_pkg::STEP_W-1:0]   r_step;

    // Controller state
    logic [lpb_pkg::DUTY_W-1:0] r_on_time;
    logic                       r_ramp_down;
    logic                       r_next_off;

    // Input register
    logic                       r_in_valid;
    lpb_pkg::t_mode             r_in_mode;
    logic [lpb_pkg::DUTY_W-1:0] r_in_duty;
    logic                       r_in_phase;

    // Result register
    logic             r_out_valid;
    lpb_pkg::t_result r_out;

    // Next values
    logic [lpb_pkg::DUTY_W-1:0] n_on_time;
    logic                       n_ramp_down;
    logic                       n_next_off;
    lpb_pkg::t_result           n_out;

    // Datapath intermediates
    logic                       advance;
    logic                       fire;
    logic [lpb_pkg::DUTY_W-1:0] step_ext;
    logic [lpb_pkg::DUTY_W-1:0] dec_time;
    logic [lpb_pkg::DUTY_W-1:0] mid_time;
    logic                       mid_down;
    logic [lpb_pkg::DUTY_W-1:0] inc_time;
    logic signed [lpb_pkg::PERIOD_W+1:0] top;
    logic                       hit_top;
    logic [lpb_pkg::DUTY_W-1:0] pulse_time;
    logic                       pulse_down;
    logic [lpb_pkg::DUTY_W-1:0] duty_sel;
    logic [lpb_pkg::DUTY_W-1:0] duty_sat;
    logic                       enable;

    // Handshake: result register frees when empty or taken
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign fire          = r_in_valid && advance;

    // Pulse ramp: decrement while ramping down; at the bottom, or while ramping up, increment in the same event
    always_comb begin
        step_ext = {1'b0, r_step};
        dec_time = r_on_time - step_ext;
        if (r_ramp_down) begin
            mid_time = dec_time;
            mid_down = !(dec_time <= step_ext);
        end else begin
            mid_time = r_on_time;
            mid_down = 1'b0;
        end
        inc_time = mid_time + step_ext;
        top      = $signed({2'b00, r_period}) - $signed({3'b000, r_step});
        hit_top  = $signed({2'b00, inc_time}) >= top;
        if (mid_down) begin
            pulse_time = mid_time;
            pulse_down = 1'b1;
        end else begin
            pulse_time = inc_time;
            pulse_down = hit_top;
        end
    end

    // Mode decode and duty saturation
    always_comb begin
        n_on_time   = r_on_time;
        n_ramp_down = r_ramp_down;
        case (r_in_mode)
            lpb_pkg::MODE_OFF: begin
                enable   = 1'b0;
                duty_sel = '0;
            end
            lpb_pkg::MODE_ON: begin
                enable   = 1'b1;
                duty_sel = r_in_duty;
            end
            lpb_pkg::MODE_BLINK: begin
                enable   = r_in_phase;
                duty_sel = r_in_duty;
            end
            default: begin
                enable      = 1'b1;
                duty_sel    = pulse_time;
                n_on_time   = pulse_time;
                n_ramp_down = pulse_down;
            end
        endcase
        duty_sat = (duty_sel > r_period) ? r_period : duty_sel;
    end

    // PWM phase choice
    always_comb begin
        n_next_off = r_next_off;
        if (enable) begin
            n_out.reload_written = 1'b1;
            if (r_next_off) begin
                n_out.led_level    = 1'b0;
                n_out.reload_value = r_period - duty_sat;
                n_next_off         = 1'b0;
            end else begin
                n_out.led_level    = 1'b1;
                n_out.reload_value = duty_sat;
                n_next_off         = 1'b1;
            end
        end else begin
            n_out.led_level      = 1'b0;
            n_out.reload_written = 1'b0;
            n_out.reload_value   = '0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= lpb_pkg::PERIOD_RESET;
            r_step   <= lpb_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpb_pkg::CFG_PWM_PERIOD: r_period <= i_cfg_data;
                lpb_pkg::CFG_PULSE_STEP: r_step   <= i_cfg_data[lpb_pkg::STEP_W-1:0];
                default:                 r_period <= r_period;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode  <= lpb_pkg::t_mode'(s_axis_tuser);
            r_in_duty  <= s_axis_tdata[lpb_pkg::DUTY_W-1:0];
            r_in_phase <= s_axis_tdata[lpb_pkg::DUTY_W];
        end
    end

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time   <= lpb_pkg::ON_TIME_RESET;
            r_ramp_down <= 1'b1;
            r_next_off  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_on_time   <= n_on_time;
                r_ramp_down <= n_ramp_down;
                r_next_off  <= n_next_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    // Output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(lpb_pkg::M_TDATA_W - lpb_pkg::DUTY_W - 1){1'b0}},
                            r_out.reload_value, r_out.led_level};
    assign m_axis_tuser  = r_out.reload_written;

    // Checks
    a_no_reload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.reload_written) |-> (r_out.reload_value == '0 && !r_out.led_level))
        else $error("result without reload carries data");

    a_phase_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && enable) |=> (r_next_off != $past(r_next_off)))
        else $error("PWM phase did not alternate on enabled event");

    a_phase_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !enable) |=> $stable(r_next_off))
        else $error("PWM phase moved on disabled event");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_duty) && $stable(r_in_mode)))
        else $error("pending input item lost during stall");

    a_ramp_only_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_mode != lpb_pkg::MODE_PULSE) |=> $stable(r_on_time))
        else $error("on-time changed outside pulse mode");

endmodule
